>>> design/vbm_pkg.sv
// package: widths, codes, microprogram and tables of the bicycle model step
`default_nettype none
package vbm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int STEER_W   = 18;
    localparam int CFG_W     = 31;
    localparam int CFG_COUNT = 8;
    localparam int CFG_IDX_W = 3;
    localparam int SLOT_W    = DATA_W + 1;
    localparam int WIDE_W    = 66;
    localparam int PROD_W    = 2 * DATA_W;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint ONE_L   = 64'sd1 <<< FRAC_BITS;
    localparam longint HALF_L  = 64'sd1 <<< (FRAC_BITS - 1);
    localparam longint OHALF_L = 64'sd3 <<< (FRAC_BITS - 1);

    localparam int     CORDIC_ITERS = 24;
    localparam int     ANG_W        = 36;
    localparam int     XY_W         = 34;
    localparam longint CORDIC_GAIN  = 64'sd652032874;
    localparam longint PI_Q30       = 64'sd3373259426;
    localparam longint HALF_PI_Q30  = 64'sd1686629713;
    localparam longint TWO_PI_Q30   = 64'sd6746518852;

    typedef enum logic [3:0] {
        OP_MUL, OP_ADD, OP_SUB, OP_ADDW, OP_CLAMP, OP_DIV, OP_TRIG, OP_TCOS,
        OP_SQA, OP_SQB, OP_SQRT, OP_END
    } op_t;

    typedef enum logic [5:0] {
        SL_K_HALF, SL_K_1P5, SL_K_ONE,
        SL_PX, SL_PY, SL_H, SL_VX, SL_VY, SL_R,
        SL_I_ST, SL_I_FX, SL_I_FF, SL_I_FR, SL_I_FFR, SL_I_FFL,
        SL_M, SL_IZ, SL_LEV, SL_BF, SL_DT, SL_DM, SL_LR, SL_WB,
        SL_T0, SL_T1, SL_SH, SL_CH, SL_SY, SL_CY, SL_XD, SL_YD, SL_VXD, SL_VYD,
        SL_RD, SL_DVX, SL_DVY, SL_DR, SL_W, SL_OMW, SL_KVX, SL_TN, SL_TV,
        SL_KVY, SL_KR, SL_NPX, SL_NPY, SL_NH, SL_NVX, SL_NVY, SL_NR
    } slot_t;

    localparam int SLOT_COUNT = 50;
    localparam int TMP_COUNT  = 27;
    localparam int TMP_IDX_W  = 5;
    localparam int STATE_N    = 6;
    localparam int PC_W       = 7;

    typedef struct packed {
        op_t   op;
        slot_t a;
        slot_t b;
        slot_t dst;
    } instr_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT, ST_COMMIT
    } ctrl_state_t;

    typedef enum logic [2:0] {
        COR_IDLE, COR_REDUCE, COR_FOLD, COR_ITER, COR_DONE
    } cor_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE, DIV_RUN, DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic   in_ready;
        logic   fetch;
        logic   exec;
        logic   commit;
        instr_t instr;
    } dp_cmd_t;

    typedef struct packed {
        logic in_accept;
        logic unit_done;
        logic out_blocked;
    } dp_status_t;

    function automatic logic signed [SLOT_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [SLOT_W-1:0] r;
        if (v > WIDE_W'(S32_MAX))
            r = SLOT_W'(S32_MAX);
        else if (v < WIDE_W'(S32_MIN))
            r = SLOT_W'(S32_MIN);
        else
            r = SLOT_W'(v);
        return r;
    endfunction

    function automatic logic is_multi(input op_t op);
        return op inside {OP_DIV, OP_TRIG, OP_SQRT};
    endfunction

    function automatic logic [CFG_W-1:0] cfg_reset(input int idx);
        logic [CFG_W-1:0] r;
        case (idx)
            0:       r = CFG_W'(13107200);
            1:       r = CFG_W'(6553600);
            2:       r = CFG_W'(52429);
            3:       r = CFG_W'(78643);
            4:       r = CFG_W'(66);
            5:       r = CFG_W'(655360);
            6:       r = CFG_W'(52429);
            default: r = CFG_W'(104858);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'd843314857;
            5'd1:    r = 32'd497837829;
            5'd2:    r = 32'd263043837;
            5'd3:    r = 32'd133525159;
            5'd4:    r = 32'd67021687;
            5'd5:    r = 32'd33543516;
            5'd6:    r = 32'd16775851;
            5'd7:    r = 32'd8388437;
            5'd8:    r = 32'd4194283;
            5'd9:    r = 32'd2097149;
            5'd10:   r = 32'd1048575;
            5'd11:   r = 32'd524287;
            5'd12:   r = 32'd262143;
            5'd13:   r = 32'd131071;
            5'd14:   r = 32'd65535;
            5'd15:   r = 32'd32767;
            5'd16:   r = 32'd16383;
            5'd17:   r = 32'd8191;
            5'd18:   r = 32'd4095;
            5'd19:   r = 32'd2047;
            5'd20:   r = 32'd1023;
            5'd21:   r = 32'd511;
            5'd22:   r = 32'd255;
            5'd23:   r = 32'd127;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic instr_t mk(input op_t op, input slot_t a, input slot_t b,
                                  input slot_t d);
        instr_t r;
        r.op  = op;
        r.a   = a;
        r.b   = b;
        r.dst = d;
        return r;
    endfunction

    // one step of the model, one operation per entry
    function automatic instr_t prog_rom(input logic [PC_W-1:0] pc);
        instr_t r;
        case (pc)
            7'd0:    r = mk(OP_TRIG,  SL_I_ST,  SL_K_ONE, SL_SH);
            7'd1:    r = mk(OP_TCOS,  SL_K_ONE, SL_K_ONE, SL_CH);
            7'd2:    r = mk(OP_TRIG,  SL_H,     SL_K_ONE, SL_SY);
            7'd3:    r = mk(OP_TCOS,  SL_K_ONE, SL_K_ONE, SL_CY);
            7'd4:    r = mk(OP_MUL,   SL_CY,    SL_VX,    SL_T0);
            7'd5:    r = mk(OP_MUL,   SL_SY,    SL_VY,    SL_T1);
            7'd6:    r = mk(OP_SUB,   SL_T0,    SL_T1,    SL_XD);
            7'd7:    r = mk(OP_MUL,   SL_SY,    SL_VX,    SL_T0);
            7'd8:    r = mk(OP_MUL,   SL_CY,    SL_VY,    SL_T1);
            7'd9:    r = mk(OP_ADD,   SL_T0,    SL_T1,    SL_YD);
            7'd10:   r = mk(OP_MUL,   SL_R,     SL_VY,    SL_T0);
            7'd11:   r = mk(OP_MUL,   SL_I_FF,  SL_SH,    SL_T1);
            7'd12:   r = mk(OP_SUB,   SL_I_FX,  SL_T1,    SL_T1);
            7'd13:   r = mk(OP_DIV,   SL_T1,    SL_M,     SL_T1);
            7'd14:   r = mk(OP_ADD,   SL_T0,    SL_T1,    SL_VXD);
            7'd15:   r = mk(OP_MUL,   SL_R,     SL_VX,    SL_T0);
            7'd16:   r = mk(OP_MUL,   SL_I_FF,  SL_CH,    SL_T1);
            7'd17:   r = mk(OP_ADD,   SL_T1,    SL_I_FR,  SL_T1);
            7'd18:   r = mk(OP_DIV,   SL_T1,    SL_M,     SL_T1);
            7'd19:   r = mk(OP_SUB,   SL_T1,    SL_T0,    SL_VYD);
            7'd20:   r = mk(OP_MUL,   SL_CH,    SL_I_FF,  SL_T0);
            7'd21:   r = mk(OP_MUL,   SL_T0,    SL_LEV,   SL_T0);
            7'd22:   r = mk(OP_SUB,   SL_I_FFR, SL_I_FFL, SL_T1);
            7'd23:   r = mk(OP_MUL,   SL_SH,    SL_T1,    SL_T1);
            7'd24:   r = mk(OP_MUL,   SL_T1,    SL_K_HALF, SL_T1);
            7'd25:   r = mk(OP_MUL,   SL_T1,    SL_BF,    SL_T1);
            7'd26:   r = mk(OP_ADD,   SL_T0,    SL_T1,    SL_T0);
            7'd27:   r = mk(OP_MUL,   SL_I_FR,  SL_LEV,   SL_T1);
            7'd28:   r = mk(OP_SUB,   SL_T0,    SL_T1,    SL_T0);
            7'd29:   r = mk(OP_DIV,   SL_T0,    SL_IZ,    SL_RD);
            7'd30:   r = mk(OP_MUL,   SL_XD,    SL_DT,    SL_T0);
            7'd31:   r = mk(OP_ADD,   SL_PX,    SL_T0,    SL_NPX);
            7'd32:   r = mk(OP_MUL,   SL_YD,    SL_DT,    SL_T0);
            7'd33:   r = mk(OP_ADD,   SL_PY,    SL_T0,    SL_NPY);
            7'd34:   r = mk(OP_MUL,   SL_R,     SL_DT,    SL_T0);
            7'd35:   r = mk(OP_ADD,   SL_H,     SL_T0,    SL_NH);
            7'd36:   r = mk(OP_MUL,   SL_VXD,   SL_DT,    SL_T0);
            7'd37:   r = mk(OP_ADD,   SL_VX,    SL_T0,    SL_DVX);
            7'd38:   r = mk(OP_MUL,   SL_VYD,   SL_DT,    SL_T0);
            7'd39:   r = mk(OP_ADD,   SL_VY,    SL_T0,    SL_DVY);
            7'd40:   r = mk(OP_MUL,   SL_RD,    SL_DT,    SL_T0);
            7'd41:   r = mk(OP_ADD,   SL_R,     SL_T0,    SL_DR);
            7'd42:   r = mk(OP_SQA,   SL_DVX,   SL_DVX,   SL_T0);
            7'd43:   r = mk(OP_SQB,   SL_DVY,   SL_DVY,   SL_T0);
            7'd44:   r = mk(OP_SQRT,  SL_K_ONE, SL_K_ONE, SL_T0);
            7'd45:   r = mk(OP_SUB,   SL_T0,    SL_K_1P5, SL_T0);
            7'd46:   r = mk(OP_MUL,   SL_K_HALF, SL_T0,   SL_T0);
            7'd47:   r = mk(OP_CLAMP, SL_T0,    SL_K_ONE, SL_W);
            7'd48:   r = mk(OP_SUB,   SL_K_ONE, SL_W,     SL_OMW);
            7'd49:   r = mk(OP_ADDW,  SL_M,     SL_DM,    SL_T0);
            7'd50:   r = mk(OP_DIV,   SL_I_FX,  SL_T0,    SL_T0);
            7'd51:   r = mk(OP_MUL,   SL_T0,    SL_DT,    SL_T0);
            7'd52:   r = mk(OP_ADD,   SL_VX,    SL_T0,    SL_KVX);
            7'd53:   r = mk(OP_MUL,   SL_W,     SL_DVX,   SL_T0);
            7'd54:   r = mk(OP_MUL,   SL_OMW,   SL_KVX,   SL_T1);
            7'd55:   r = mk(OP_ADD,   SL_T0,    SL_T1,    SL_NVX);
            7'd56:   r = mk(OP_DIV,   SL_SH,    SL_CH,    SL_TN);
            7'd57:   r = mk(OP_MUL,   SL_TN,    SL_NVX,   SL_TV);
            7'd58:   r = mk(OP_MUL,   SL_TV,    SL_LR,    SL_T0);
            7'd59:   r = mk(OP_DIV,   SL_T0,    SL_WB,    SL_KVY);
            7'd60:   r = mk(OP_DIV,   SL_TV,    SL_WB,    SL_KR);
            7'd61:   r = mk(OP_MUL,   SL_W,     SL_DVY,   SL_T0);
            7'd62:   r = mk(OP_MUL,   SL_OMW,   SL_KVY,   SL_T1);
            7'd63:   r = mk(OP_ADD,   SL_T0,    SL_T1,    SL_NVY);
            7'd64:   r = mk(OP_MUL,   SL_W,     SL_DR,    SL_T0);
            7'd65:   r = mk(OP_MUL,   SL_OMW,   SL_KR,    SL_T1);
            7'd66:   r = mk(OP_ADD,   SL_T0,    SL_T1,    SL_NR);
            default: r = mk(OP_END,   SL_K_ONE, SL_K_ONE, SL_T0);
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/vbm_if.sv
// stream interfaces for the step input and the new state output
`default_nettype none
interface vbm_in_if;
    import vbm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [STEER_W-1:0] steer_angle;
    logic signed [DATA_W-1:0]  long_force;
    logic signed [DATA_W-1:0]  front_lat_force;
    logic signed [DATA_W-1:0]  rear_lat_force;
    logic signed [DATA_W-1:0]  front_right_lat_force;
    logic signed [DATA_W-1:0]  front_left_lat_force;
    modport source (output valid, steer_angle, long_force, front_lat_force, rear_lat_force,
                    front_right_lat_force, front_left_lat_force, input ready);
    modport sink (input valid, steer_angle, long_force, front_lat_force, rear_lat_force,
                  front_right_lat_force, front_left_lat_force, output ready);
endinterface

interface vbm_out_if;
    import vbm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] new_pos_x;
    logic signed [DATA_W-1:0] new_pos_y;
    logic signed [DATA_W-1:0] new_heading;
    logic signed [DATA_W-1:0] new_vel_long;
    logic signed [DATA_W-1:0] new_vel_lat;
    logic signed [DATA_W-1:0] new_yaw_rate;
    modport source (output valid, new_pos_x, new_pos_y, new_heading, new_vel_long,
                    new_vel_lat, new_yaw_rate, input ready);
    modport sink (input valid, new_pos_x, new_pos_y, new_heading, new_vel_long,
                  new_vel_lat, new_yaw_rate, output ready);
endinterface
`default_nettype wire

>>> design/vbm_div.sv
// restoring fixed point divider, one quotient bit per cycle, saturating
`default_nettype none
module vbm_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic signed [vbm_pkg::SLOT_W-1:0] num,
    input  wire logic signed [vbm_pkg::SLOT_W-1:0] den,
    output logic                                  done,
    output logic signed [vbm_pkg::SLOT_W-1:0]     quot
);
    import vbm_pkg::*;

    localparam int NUM_W = DATA_W + FRAC_BITS;
    localparam int DEN_W = SLOT_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    div_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [NUM_W-1:0]   q_reg;
    logic [DEN_W:0]     rem_reg;
    logic [DEN_W-1:0]   d_reg;
    logic               neg_reg, zden_reg, npos_reg, nneg_reg;

    logic [SLOT_W-1:0]  nmag, dmag;
    logic [DEN_W:0]     rem_sh;
    logic               qbit;

    always_comb
    begin
        nmag   = num[SLOT_W-1] ? SLOT_W'(-num) : SLOT_W'(num);
        dmag   = den[SLOT_W-1] ? SLOT_W'(-den) : SLOT_W'(den);
        rem_sh = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
        qbit   = (rem_sh >= {1'b0, d_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                    state_next = (den == '0) ? DIV_DONE : DIV_RUN;
            end
            DIV_RUN:
            begin
                if (cnt_reg == CNT_W'(1))
                    state_next = DIV_DONE;
            end
            DIV_DONE: state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DIV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && start)
        begin
            q_reg    <= NUM_W'(nmag[DATA_W-1:0]) << FRAC_BITS;
            rem_reg  <= '0;
            d_reg    <= dmag;
            cnt_reg  <= CNT_W'(NUM_W);
            neg_reg  <= num[SLOT_W-1] ^ den[SLOT_W-1];
            zden_reg <= (den == '0);
            npos_reg <= !num[SLOT_W-1] && (num != '0);
            nneg_reg <= num[SLOT_W-1];
        end
        else if (state_reg == DIV_RUN)
        begin
            rem_reg <= qbit ? rem_sh - {1'b0, d_reg} : rem_sh;
            q_reg   <= {q_reg[NUM_W-2:0], qbit};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        done = (state_reg == DIV_DONE);
        if (zden_reg)
            quot = npos_reg ? SLOT_W'(S32_MAX) : (nneg_reg ? SLOT_W'(S32_MIN) : '0);
        else if (!neg_reg)
            quot = (q_reg > NUM_W'(S32_MAX)) ? SLOT_W'(S32_MAX) : SLOT_W'(q_reg);
        else
            quot = (q_reg > NUM_W'(S32_MAX + 1)) ? SLOT_W'(S32_MIN) : SLOT_W'(-q_reg);
    end

endmodule
`default_nettype wire

>>> design/vbm_cordic.sv
// iterative sine and cosine: range reduction, fold, rotation cordic in q2.30
`default_nettype none
module vbm_cordic (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic signed [vbm_pkg::SLOT_W-1:0] angle,
    output logic                                  done,
    output logic signed [vbm_pkg::SLOT_W-1:0]     sin_out,
    output logic signed [vbm_pkg::SLOT_W-1:0]     cos_out
);
    import vbm_pkg::*;

    localparam int SCALE     = 30 - FRAC_BITS;
    localparam int MAG_W     = DATA_W + SCALE;
    localparam int RED_STEPS = MAG_W - 32;
    localparam logic signed [ANG_W-1:0] PI_A  = ANG_W'(PI_Q30);
    localparam logic signed [ANG_W-1:0] HPI_A = ANG_W'(HALF_PI_Q30);
    localparam logic signed [ANG_W-1:0] TPI_A = ANG_W'(TWO_PI_Q30);

    cor_state_t               state_reg, state_next;
    logic [MAG_W-1:0]         m_reg;
    logic                     sgn_reg, flip_reg;
    logic [4:0]               k_reg, i_reg;
    logic signed [ANG_W-1:0]  t_reg;
    logic signed [XY_W-1:0]   x_reg, y_reg;

    logic [SLOT_W-1:0]        amag;
    logic [MAG_W:0]           modv;
    logic signed [ANG_W-1:0]  t_f, at;
    logic                     flip_f;
    logic signed [XY_W-1:0]   xs, ys, xf, yf;

    always_comb
    begin
        amag = angle[SLOT_W-1] ? SLOT_W'(-angle) : SLOT_W'(angle);
        modv = (MAG_W + 1)'(TWO_PI_Q30) << k_reg;

        // fold into [-pi/2, pi/2]
        t_f    = sgn_reg ? -$signed({2'b00, m_reg[33:0]}) : $signed({2'b00, m_reg[33:0]});
        flip_f = 1'b0;
        if (t_f > PI_A)
            t_f = t_f - TPI_A;
        if (t_f < -PI_A)
            t_f = t_f + TPI_A;
        if (t_f > HPI_A)
        begin
            t_f    = t_f - PI_A;
            flip_f = 1'b1;
        end
        else if (t_f < -HPI_A)
        begin
            t_f    = t_f + PI_A;
            flip_f = 1'b1;
        end

        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = $signed(ANG_W'(atan_entry(i_reg)));

        xf      = flip_reg ? -x_reg : x_reg;
        yf      = flip_reg ? -y_reg : y_reg;
        sin_out = sat32(WIDE_W'(yf >>> SCALE));
        cos_out = sat32(WIDE_W'(xf >>> SCALE));
        done    = (state_reg == COR_DONE);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            COR_IDLE:   if (start) state_next = COR_REDUCE;
            COR_REDUCE: if (k_reg == 5'd0) state_next = COR_FOLD;
            COR_FOLD:   state_next = COR_ITER;
            COR_ITER:   if (i_reg == 5'(CORDIC_ITERS - 1)) state_next = COR_DONE;
            COR_DONE:   state_next = COR_IDLE;
            default:    state_next = COR_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= COR_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            COR_IDLE:
            begin
                if (start)
                begin
                    m_reg   <= MAG_W'(amag[DATA_W-1:0]) << SCALE;
                    sgn_reg <= angle[SLOT_W-1];
                    k_reg   <= 5'(RED_STEPS - 1);
                end
            end
            COR_REDUCE:
            begin
                if ({1'b0, m_reg} >= modv)
                    m_reg <= m_reg - modv[MAG_W-1:0];
                k_reg <= k_reg - 5'd1;
            end
            COR_FOLD:
            begin
                t_reg    <= t_f;
                flip_reg <= flip_f;
                x_reg    <= XY_W'(CORDIC_GAIN);
                y_reg    <= '0;
                i_reg    <= 5'd0;
            end
            COR_ITER:
            begin
                if (t_reg >= 0)
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    t_reg <= t_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    t_reg <= t_reg + at;
                end
                i_reg <= i_reg + 5'd1;
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

>>> design/vbm_datapath.sv
// datapath: operand slots, multiplier, adder, square root and the shared units
`default_nettype none
module vbm_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire vbm_pkg::dp_cmd_t              cmd,
    output vbm_pkg::dp_status_t                status,
    vbm_in_if.sink                             in_ch,
    vbm_out_if.source                          out_ch,
    input  wire logic                          cfg_we,
    input  wire logic [vbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [vbm_pkg::CFG_W-1:0]     cfg_data
);
    import vbm_pkg::*;

    localparam int TMP_BASE = int'(SL_T0);
    localparam int CFG_BASE = int'(SL_M);
    localparam int ST_BASE  = int'(SL_PX);
    localparam int NST_BASE = int'(SL_NPX) - TMP_BASE;

    logic [CFG_W-1:0]          cfg_reg [CFG_COUNT];
    logic signed [DATA_W-1:0]  st_reg  [STATE_N];
    logic signed [STEER_W-1:0] in_st_reg;
    logic signed [DATA_W-1:0]  in_fx_reg, in_ff_reg, in_fr_reg, in_ffr_reg, in_ffl_reg;
    logic signed [SLOT_W-1:0]  tmp_reg [TMP_COUNT];
    logic signed [SLOT_W-1:0]  op_a_reg, op_b_reg;
    logic [PROD_W-1:0]         acc_reg;
    logic                      out_valid_reg;

    logic [PROD_W-1:0]         sq_rem_reg, sq_res_reg, sq_bit_reg;
    logic                      sq_busy_reg, sq_done_reg;

    logic signed [SLOT_W-1:0]  slot_view [SLOT_COUNT];
    logic signed [PROD_W-1:0]  prod;
    logic signed [SLOT_W-1:0]  alu_res, unit_res, wr_data, sq_out;
    logic                      wr_en, in_accept;
    logic [TMP_IDX_W-1:0]      wr_idx;
    logic [PROD_W:0]           sq_trial;

    logic                      div_start, div_done, cor_start, cor_done, sq_start;
    logic signed [SLOT_W-1:0]  div_q, cor_sin, cor_cos;

    vbm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (op_a_reg),
        .den   (op_b_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    vbm_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (op_a_reg),
        .done    (cor_done),
        .sin_out (cor_sin),
        .cos_out (cor_cos)
    );

    always_comb
    begin
        slot_view[SL_K_HALF] = SLOT_W'(HALF_L);
        slot_view[SL_K_1P5]  = SLOT_W'(OHALF_L);
        slot_view[SL_K_ONE]  = SLOT_W'(ONE_L);
        for (int i = 0; i < STATE_N; i++)
            slot_view[ST_BASE + i] = SLOT_W'(st_reg[i]);
        slot_view[SL_I_ST]  = SLOT_W'(in_st_reg);
        slot_view[SL_I_FX]  = SLOT_W'(in_fx_reg);
        slot_view[SL_I_FF]  = SLOT_W'(in_ff_reg);
        slot_view[SL_I_FR]  = SLOT_W'(in_fr_reg);
        slot_view[SL_I_FFR] = SLOT_W'(in_ffr_reg);
        slot_view[SL_I_FFL] = SLOT_W'(in_ffl_reg);
        for (int i = 0; i < CFG_COUNT; i++)
            slot_view[CFG_BASE + i] = $signed({2'b00, cfg_reg[i]});
        for (int i = 0; i < TMP_COUNT; i++)
            slot_view[TMP_BASE + i] = tmp_reg[i];
    end

    // results of the operations that complete without waiting on a unit
    always_comb
    begin
        prod = $signed(op_a_reg[DATA_W-1:0]) * $signed(op_b_reg[DATA_W-1:0]);
        case (cmd.instr.op)
            OP_MUL:   alu_res = sat32(WIDE_W'(prod >>> FRAC_BITS));
            OP_ADD:   alu_res = sat32(WIDE_W'(op_a_reg) + WIDE_W'(op_b_reg));
            OP_SUB:   alu_res = sat32(WIDE_W'(op_a_reg) - WIDE_W'(op_b_reg));
            OP_ADDW:  alu_res = op_a_reg + op_b_reg;
            OP_CLAMP:
            begin
                if (op_a_reg < 0)
                    alu_res = '0;
                else if (op_a_reg > SLOT_W'(ONE_L))
                    alu_res = SLOT_W'(ONE_L);
                else
                    alu_res = op_a_reg;
            end
            OP_TCOS:  alu_res = cor_cos;
            default:  alu_res = '0;
        endcase
    end

    always_comb
    begin
        sq_trial = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
        sq_out   = (sq_res_reg > PROD_W'(S32_MAX)) ? SLOT_W'(S32_MAX) : SLOT_W'(sq_res_reg);
        case (cmd.instr.op)
            OP_DIV:  unit_res = div_q;
            OP_TRIG: unit_res = cor_sin;
            default: unit_res = sq_out;
        endcase
        div_start = cmd.exec && (cmd.instr.op == OP_DIV);
        cor_start = cmd.exec && (cmd.instr.op == OP_TRIG);
        sq_start  = cmd.exec && (cmd.instr.op == OP_SQRT);
        wr_en   = status.unit_done ||
                  (cmd.exec && !is_multi(cmd.instr.op) &&
                   !(cmd.instr.op inside {OP_SQA, OP_SQB, OP_END}));
        wr_data = status.unit_done ? unit_res : alu_res;
        wr_idx  = TMP_IDX_W'(int'(cmd.instr.dst) - TMP_BASE);
    end

    always_comb
    begin
        in_accept          = in_ch.valid && cmd.in_ready;
        in_ch.ready        = cmd.in_ready;
        status.in_accept   = in_accept;
        status.unit_done   = div_done || cor_done || sq_done_reg;
        status.out_blocked = out_valid_reg && !out_ch.ready;
        out_ch.valid        = out_valid_reg;
        out_ch.new_pos_x    = st_reg[0];
        out_ch.new_pos_y    = st_reg[1];
        out_ch.new_heading  = st_reg[2];
        out_ch.new_vel_long = st_reg[3];
        out_ch.new_vel_lat  = st_reg[4];
        out_ch.new_yaw_rate = st_reg[5];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
                cfg_reg[i] <= cfg_reset(i);
            for (int i = 0; i < STATE_N; i++)
                st_reg[i] <= '0;
            out_valid_reg <= 1'b0;
            sq_busy_reg   <= 1'b0;
            sq_done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cfg_reg[cfg_index] <= cfg_data;
            if (cmd.commit)
            begin
                for (int i = 0; i < STATE_N; i++)
                    st_reg[i] <= DATA_W'(tmp_reg[NST_BASE + i]);
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            sq_done_reg <= sq_busy_reg && (sq_bit_reg == PROD_W'(1));
            if (sq_start)
                sq_busy_reg <= 1'b1;
            else if (sq_bit_reg == PROD_W'(1))
                sq_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_st_reg  <= in_ch.steer_angle;
            in_fx_reg  <= in_ch.long_force;
            in_ff_reg  <= in_ch.front_lat_force;
            in_fr_reg  <= in_ch.rear_lat_force;
            in_ffr_reg <= in_ch.front_right_lat_force;
            in_ffl_reg <= in_ch.front_left_lat_force;
        end
        if (cmd.fetch)
        begin
            op_a_reg <= slot_view[cmd.instr.a];
            op_b_reg <= slot_view[cmd.instr.b];
        end
        if (wr_en)
            tmp_reg[wr_idx] <= wr_data;
        if (cmd.exec && cmd.instr.op == OP_SQA)
            acc_reg <= PROD_W'(prod);
        else if (cmd.exec && cmd.instr.op == OP_SQB)
            acc_reg <= acc_reg + PROD_W'(prod);
        // bit-pair square root, two bits of the radicand per cycle
        if (sq_start)
        begin
            sq_rem_reg <= acc_reg;
            sq_res_reg <= '0;
            sq_bit_reg <= PROD_W'(1) << (PROD_W - 2);
        end
        else if (sq_busy_reg)
        begin
            if ({1'b0, sq_rem_reg} >= sq_trial)
            begin
                sq_rem_reg <= sq_rem_reg - PROD_W'(sq_trial);
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end
            else
                sq_res_reg <= sq_res_reg >> 1;
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

endmodule
`default_nettype wire

>>> design/vbm_ctrl.sv
// controller: steps the microprogram, one operation per fetch and execute pair
`default_nettype none
module vbm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire vbm_pkg::dp_status_t status,
    output vbm_pkg::dp_cmd_t         cmd
);
    import vbm_pkg::*;

    ctrl_state_t     state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    instr_t          instr;

    always_comb
    begin
        instr        = prog_rom(pc_reg);
        state_next   = state_reg;
        pc_next      = pc_reg;
        cmd.in_ready = 1'b0;
        cmd.fetch    = 1'b0;
        cmd.exec     = 1'b0;
        cmd.commit   = 1'b0;
        cmd.instr    = instr;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_accept)
                begin
                    pc_next    = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (instr.op == OP_END)
                    state_next = ST_COMMIT;
                else
                begin
                    cmd.fetch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (is_multi(instr.op))
                    state_next = ST_WAIT;
                else
                begin
                    pc_next    = pc_reg + PC_W'(1);
                    state_next = ST_FETCH;
                end
            end
            ST_WAIT:
            begin
                if (status.unit_done)
                begin
                    pc_next    = pc_reg + PC_W'(1);
                    state_next = ST_FETCH;
                end
            end
            ST_COMMIT:
            begin
                if (!status.out_blocked)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule
`default_nettype wire

>>> design/vehicle_bicycle_model_step.sv
// top level: blended dynamic and kinematic bicycle model, one time step per transaction
//
// in_ch carries one time step (steering angle and tyre forces); out_ch returns the
// new pose and velocities, which are also the stored state for the next step.
// cfg_we/cfg_index/cfg_data write the eight vehicle registers; the user must write them
// only while idle, as the block itself leaves this unchecked. the step runs as a
// microprogram of 67 operations; the simple operations take an operand fetch and
// then an execute, the seven divides run in the one-bit-per-cycle divider, the two
// sin/cos evaluations run range reduction plus 24 cordic rotations, and the square
// root runs bit pair by bit pair. a new step is taken only once the previous one
// has been committed, so the shared divider serves one step at a time.
// reset: state clears to zero, registers take their default vehicle values,
// no output is pending and the block is ready for a step.
// a stalled receiver holds the result on out_ch; the next step is still taken
// and computed, and only its final state update waits until the result is taken.
`default_nettype none
module vehicle_bicycle_model_step (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    vbm_in_if.sink                             in_ch,
    vbm_out_if.source                          out_ch,
    input  wire logic                          cfg_we,
    input  wire logic [vbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [vbm_pkg::CFG_W-1:0]     cfg_data
);
    import vbm_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer walks the step program and handshakes with the units
    vbm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // datapath holds state, inputs, registers, temporaries and the arithmetic
    vbm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
`default_nettype wire

>>> verif/vehicle_bicycle_model_step_test.sv
// testbench for vehicle_bicycle_model_step: random and directed steps against a fixed-point predictor
`default_nettype none
module vehicle_bicycle_model_step_test;
    import vbm_pkg::*;

    // register indexes, in the order of the block's register file
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MASS, REG_INERTIA, REG_LEVER, REG_TRACK, REG_DT, REG_DRIVELINE, REG_CG_REAR,
        REG_WHEELBASE
    } cfg_reg_e;

    // one time step as it goes into the block
    typedef struct {
        logic signed [STEER_W-1:0] steer;
        logic signed [DATA_W-1:0]  fx;
        logic signed [DATA_W-1:0]  ff;
        logic signed [DATA_W-1:0]  fr;
        logic signed [DATA_W-1:0]  ffr;
        logic signed [DATA_W-1:0]  ffl;
    } step_t;

    // the vehicle state as it comes out of the block
    typedef struct {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] hd;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] yr;
    } pose_t;

    // fixed-point vehicle model kept alongside the block, plus the queue of states
    // still owed by it
    class vehicle_scoreboard;
        longint regs[CFG_COUNT];
        longint px, py, hd, vx, vy, yr;
        pose_t  owed_q[$];
        int     errors;

        function new();
            for (int i = 0; i < CFG_COUNT; i++)
                regs[i] = longint'(cfg_reset(i));
            px = 0; py = 0; hd = 0; vx = 0; vy = 0; yr = 0;
            errors = 0;
        endfunction

        function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
            regs[idx] = longint'(val);
        endfunction

        function longint sat(longint v);
            if (v > S32_MAX)
                return S32_MAX;
            if (v < S32_MIN)
                return S32_MIN;
            return v;
        endfunction

        // product floors toward minus infinity
        function longint qmul(longint a, longint b);
            return sat((a * b) >>> FRAC_BITS);
        endfunction

        // quotient truncates toward zero, zero divisor saturates by numerator sign
        function longint qdiv(longint n, longint d);
            if (d == 0)
                return n > 0 ? S32_MAX : (n < 0 ? S32_MIN : 64'sd0);
            return sat((n * ONE_L) / d);
        endfunction

        function longint qblend(longint w, longint a, longint b);
            return sat(qmul(w, a) + qmul(ONE_L - w, b));
        endfunction

        // rotation cordic in q2.30 after folding into [-pi/2, pi/2]
        function void sin_cos(longint ang, output longint s, output longint c);
            longint t, x, y, nx;
            bit     flip;
            t = (ang * (64'sd1 <<< (30 - FRAC_BITS))) % TWO_PI_Q30;
            x = CORDIC_GAIN;
            y = 0;
            flip = 0;
            if (t > PI_Q30) t -= TWO_PI_Q30;
            if (t < -PI_Q30) t += TWO_PI_Q30;
            if (t > HALF_PI_Q30)
            begin
                t -= PI_Q30;
                flip = 1;
            end
            else if (t < -HALF_PI_Q30)
            begin
                t += PI_Q30;
                flip = 1;
            end
            for (int i = 0; i < CORDIC_ITERS; i++)
            begin
                if (t >= 0)
                begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    t -= longint'(atan_entry(5'(i)));
                end
                else
                begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    t += longint'(atan_entry(5'(i)));
                end
                x = nx;
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            s = sat(y >>> (30 - FRAC_BITS));
            c = sat(x >>> (30 - FRAC_BITS));
        endfunction

        function longint floor_sqrt(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return longint'(r);
        endfunction

        // advance the model by one accepted step and queue the state it yields
        function void note_step(step_t s);
            longint sh, ch, sy, cy, xd, yd, vxd, vyd, rnum, rd;
            longint nx, ny, nh, dvx, dvy, dr, spd, w, kvx, tn, tv, kvy, kr;
            longint fvx, fvy, fyr, fx, ff, fr;
            longint unsigned sq;
            pose_t  p;
            fx = s.fx; ff = s.ff; fr = s.fr;
            sin_cos(longint'(s.steer), sh, ch);
            sin_cos(hd, sy, cy);
            xd   = sat(qmul(cy, vx) - qmul(sy, vy));
            yd   = sat(qmul(sy, vx) + qmul(cy, vy));
            vxd  = sat(qmul(yr, vy) + qdiv(sat(fx - qmul(ff, sh)), regs[REG_MASS]));
            vyd  = sat(-qmul(yr, vx) + qdiv(sat(qmul(ff, ch) + fr), regs[REG_MASS]));
            rnum = sat(qmul(qmul(ch, ff), regs[REG_LEVER])
                       + qmul(qmul(qmul(sh, sat(longint'(s.ffr) - longint'(s.ffl))), HALF_L),
                              regs[REG_TRACK]));
            rnum = sat(rnum - qmul(fr, regs[REG_LEVER]));
            rd   = qdiv(rnum, regs[REG_INERTIA]);
            nx   = sat(px + qmul(xd, regs[REG_DT]));
            ny   = sat(py + qmul(yd, regs[REG_DT]));
            nh   = sat(hd + qmul(yr, regs[REG_DT]));
            dvx  = sat(vx + qmul(vxd, regs[REG_DT]));
            dvy  = sat(vy + qmul(vyd, regs[REG_DT]));
            dr   = sat(yr + qmul(rd, regs[REG_DT]));
            // blend weight from the dynamic speed
            sq   = longint'(dvx * dvx);
            sq   = sq + longint'(dvy * dvy);
            spd  = sat(floor_sqrt(sq));
            w    = qmul(HALF_L, spd - OHALF_L);
            if (w < 0) w = 0;
            if (w > ONE_L) w = ONE_L;
            kvx  = sat(vx + qmul(qdiv(fx, regs[REG_MASS] + regs[REG_DRIVELINE]), regs[REG_DT]));
            fvx  = qblend(w, dvx, kvx);
            tn   = qdiv(sh, ch);
            tv   = qmul(tn, fvx);
            kvy  = qdiv(qmul(tv, regs[REG_CG_REAR]), regs[REG_WHEELBASE]);
            kr   = qdiv(tv, regs[REG_WHEELBASE]);
            fvy  = qblend(w, dvy, kvy);
            fyr  = qblend(w, dr, kr);
            px = nx; py = ny; hd = nh; vx = fvx; vy = fvy; yr = fyr;
            p.px = px[31:0]; p.py = py[31:0]; p.hd = hd[31:0];
            p.vx = vx[31:0]; p.vy = vy[31:0]; p.yr = yr[31:0];
            owed_q.push_back(p);
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        endtask

        task check_pose(pose_t got);
            pose_t want;
            if (owed_q.size() == 0)
            begin
                report("unexpected state transaction", got.px, 0);
                return;
            end
            want = owed_q.pop_front();
            if (got.px !== want.px) report("new_pos_x", got.px, want.px);
            if (got.py !== want.py) report("new_pos_y", got.py, want.py);
            if (got.hd !== want.hd) report("new_heading", got.hd, want.hd);
            if (got.vx !== want.vx) report("new_vel_long", got.vx, want.vx);
            if (got.vy !== want.vy) report("new_vel_lat", got.vy, want.vy);
            if (got.yr !== want.yr) report("new_yaw_rate", got.yr, want.yr);
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    bit                   quiet;

    vbm_in_if  in_ch ();
    vbm_out_if out_ch ();
    vehicle_scoreboard board;

    vehicle_bicycle_model_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // hard stop, far above the slowest correct run
    initial
    begin
        #60000000;
        $display("vehicle_bicycle_model_step test failed");
        $finish;
    end

    // force in newtons: mostly within lo..hi, sometimes any 32-bit pattern, an extreme or zero
    function automatic logic signed [DATA_W-1:0] pick_force(int lo, int hi);
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 3)
            return $urandom;
        if (sel == 3)
            return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        if (sel == 4)
            return '0;
        return DATA_W'((lo + int'($urandom_range(0, hi - lo))) * 65536
                       + int'($urandom_range(0, 65535)));
    endfunction

    // random step: steering mostly within one radian, sometimes the whole 18-bit range
    function automatic step_t random_step();
        step_t s;
        if ($urandom_range(0, 9) == 0)
            s.steer = STEER_W'($urandom);
        else
            s.steer = STEER_W'(int'($urandom_range(0, 131072)) - 65536);
        s.fx  = pick_force(-500, 3000);
        s.ff  = pick_force(-1500, 1500);
        s.fr  = pick_force(-1500, 1500);
        s.ffr = pick_force(-800, 800);
        s.ffl = pick_force(-800, 800);
        return s;
    endfunction

    function automatic step_t make_step(int st, int fx, int ff, int fr, int ffr, int ffl);
        step_t s;
        s.steer = STEER_W'(st);
        s.fx = fx; s.ff = ff; s.fr = fr; s.ffr = ffr; s.ffl = ffl;
        return s;
    endfunction

    // offer one step; valid stays high after the transaction so back-to-back steps
    // need no second assignment in the same time step
    task send_step(step_t s);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_ch.valid                 <= 1'b1;
        in_ch.steer_angle           <= s.steer;
        in_ch.long_force            <= s.fx;
        in_ch.front_lat_force       <= s.ff;
        in_ch.rear_lat_force        <= s.fr;
        in_ch.front_right_lat_force <= s.ffr;
        in_ch.front_left_lat_force  <= s.ffl;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        board.note_step(s);
    endtask

    // drop valid and let every owed state come back before going on
    task drain();
        in_ch.valid <= 1'b0;
        while (board.owed_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // write all eight registers, back to back, while the block is idle
    task program_regs(logic [CFG_W-1:0] vals[CFG_COUNT]);
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_e'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            board.set_reg(cfg_reg_e'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // register sets: typical, random, low extremes, high extremes, else reset values with a short dt
    function automatic void pick_regs(int kind, output logic [CFG_W-1:0] vals[CFG_COUNT]);
        for (int i = 0; i < CFG_COUNT; i++)
            vals[i] = cfg_reset(i);
        case (kind)
            0:
            begin
                vals[REG_DT] = CFG_W'(6554);
            end
            1:
            begin
                vals[REG_MASS]      = CFG_W'($urandom_range(1, 1000) * 65536);
                vals[REG_INERTIA]   = CFG_W'($urandom_range(1, 500) * 65536);
                vals[REG_LEVER]     = CFG_W'($urandom_range(0, 200000));
                vals[REG_TRACK]     = CFG_W'($urandom);
                vals[REG_DT]        = CFG_W'($urandom_range(1, 20000));
                vals[REG_DRIVELINE] = CFG_W'($urandom);
                vals[REG_CG_REAR]   = CFG_W'($urandom_range(0, 200000));
                vals[REG_WHEELBASE] = CFG_W'($urandom_range(1, 400000));
            end
            2:
            begin
                vals[REG_MASS]      = CFG_W'(1);
                vals[REG_INERTIA]   = CFG_W'(1);
                vals[REG_LEVER]     = '0;
                vals[REG_TRACK]     = '0;
                vals[REG_DT]        = CFG_W'(1);
                vals[REG_DRIVELINE] = '0;
                vals[REG_CG_REAR]   = '0;
                vals[REG_WHEELBASE] = CFG_W'(1);
            end
            3:
            begin
                for (int i = 0; i < CFG_COUNT; i++)
                    vals[i] = '1;
            end
            default:
            begin
                vals[REG_DT] = CFG_W'(655);
            end
        endcase
    endfunction

    // result side: ready stalls in random bursts, none in the quiet tail
    initial
    begin
        int    hold;
        pose_t got;
        hold = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.px = out_ch.new_pos_x;
                got.py = out_ch.new_pos_y;
                got.hd = out_ch.new_heading;
                got.vx = out_ch.new_vel_long;
                got.vy = out_ch.new_vel_lat;
                got.yr = out_ch.new_yaw_rate;
                board.check_pose(got);
            end
            if (hold > 0)
            begin
                hold--;
                out_ch.ready <= 1'b0;
            end
            else if (!quiet && rst_n && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 12) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // main sequence
    initial
    begin
        step_t            dir_q[$];
        logic [CFG_W-1:0] vals[CFG_COUNT];
        int               order[6];
        board = new();
        quiet = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.steer_angle <= '0;
        in_ch.long_force <= '0;
        in_ch.front_lat_force <= '0;
        in_ch.rear_lat_force <= '0;
        in_ch.front_right_lat_force <= '0;
        in_ch.front_left_lat_force <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero step, steering extremes, quarter turn where cos reaches zero,
        // force extremes, opposite front wheel forces
        dir_q.push_back(make_step(0, 0, 0, 0, 0, 0));
        dir_q.push_back(make_step(65536, 1000 << 16, 0, 0, 0, 0));
        dir_q.push_back(make_step(-65536, 1000 << 16, 0, 0, 0, 0));
        dir_q.push_back(make_step(131071, 0, 100 << 16, 0, 0, 0));
        dir_q.push_back(make_step(-131072, 0, -100 << 16, 0, 0, 0));
        dir_q.push_back(make_step(102944, 500 << 16, 0, 0, 0, 0));
        dir_q.push_back(make_step(-102944, 500 << 16, 0, 0, 0, 0));
        dir_q.push_back(make_step(0, 32'sh7fffffff, 0, 0, 0, 0));
        dir_q.push_back(make_step(0, 32'sh80000000, 0, 0, 0, 0));
        dir_q.push_back(make_step(30000, 0, 32'sh7fffffff, 32'sh80000000, 0, 0));
        dir_q.push_back(make_step(-30000, 0, 32'sh80000000, 32'sh7fffffff, 0, 0));
        dir_q.push_back(make_step(40000, 0, 0, 0, 32'sh7fffffff, 32'sh80000000));
        dir_q.push_back(make_step(-40000, 0, 0, 0, 32'sh80000000, 32'sh7fffffff));
        dir_q.push_back(make_step(20000, -1, -1, -1, -1, -1));
        dir_q.push_back(make_step(-1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                                  32'sh7fffffff, 32'sh7fffffff));
        dir_q.push_back(make_step(1, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                                  32'sh80000000, 32'sh80000000));
        dir_q.push_back(make_step(0, 2000 << 16, 300 << 16, -300 << 16, 50 << 16,
                                  -50 << 16));
        foreach (dir_q[i])
            send_step(dir_q[i]);

        // random phases under different register sets; the last one is the reset
        // values with a short time step, with no idling on either side
        order = '{0, 1, 4, 2, 3, 5};
        foreach (order[p])
        begin
            drain();
            pick_regs(order[p], vals);
            program_regs(vals);
            if (p == 5)
                quiet = 1;
            for (int n = 0; n < 165; n++)
                send_step(random_step());
        end

        drain();
        repeat (600) @(posedge clk);
        if (board.errors == 0 && board.owed_q.size() == 0)
            $display("vehicle_bicycle_model_step test passed");
        else
            $display("vehicle_bicycle_model_step test failed");
        $finish;
    end

endmodule
`default_nettype wire

>>> vehicle_bicycle_model_step.f
design/vbm_pkg.sv
design/vbm_if.sv
design/vbm_div.sv
design/vbm_cordic.sv
design/vbm_datapath.sv
design/vbm_ctrl.sv
design/vehicle_bicycle_model_step.sv
verif/vehicle_bicycle_model_step_test.sv
